// ===== rtl/core/r2a_pkg.sv =====
// Shared constants, types and a helper function for the radix to ASCII converter.
`default_nettype none

package r2a_pkg;

    localparam int VALUE_BITS        = 31;
    localparam int DIGIT_STACK_DEPTH = 32;
    localparam int BASE_W            = 5;
    localparam int DIGIT_W           = 4;
    localparam int CHAR_W            = 7;

    localparam int SP_W  = $clog2(DIGIT_STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(DIGIT_STACK_DEPTH);

    localparam int IN_TDATA_W  = ((VALUE_BITS + BASE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W      = DIV_CYCLES * DIV_STEPS;
    localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_OCT = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_NUL  = CHAR_W'(0);
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_X    = CHAR_W'(8'h58);
    localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(8'h41);
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [BASE_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_W-1:0]    remainder;
    } div_rsp_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d <= DIGIT_NINE) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/r2a_divider.sv =====
// Multi-cycle restoring divider of the value by a small radix.
`default_nettype none

module r2a_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire r2a_pkg::div_req_t req,
    output r2a_pkg::div_rsp_t      rsp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [r2a_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [r2a_pkg::DIV_W-1:0]        dvd_reg, dvd_next;
    logic [r2a_pkg::DIGIT_W-1:0]      rem_reg, rem_next;
    logic [r2a_pkg::BASE_W-1:0]       dsr_reg, dsr_next;

    logic [r2a_pkg::DIV_W-1:0]        step_dvd;
    logic [r2a_pkg::DIGIT_W-1:0]      step_rem;
    logic [r2a_pkg::DIGIT_W:0]        trial;

    // Eight restoring steps per cycle. The partial remainder stays below the
    // divisor, so it fits in a digit, and the trial value in one bit more.
    always_comb begin
        step_dvd = dvd_reg;
        step_rem = rem_reg;
        trial    = '0;
        for (int i = 0; i < r2a_pkg::DIV_STEPS; i++) begin
            trial    = {step_rem, step_dvd[r2a_pkg::DIV_W-1]};
            step_dvd = {step_dvd[r2a_pkg::DIV_W-2:0], 1'b0};
            if (trial >= (r2a_pkg::DIGIT_W+1)'(dsr_reg)) begin
                step_rem    = r2a_pkg::DIGIT_W'(trial - (r2a_pkg::DIGIT_W+1)'(dsr_reg));
                step_dvd[0] = 1'b1;
            end else begin
                step_rem = r2a_pkg::DIGIT_W'(trial);
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (busy_reg) begin
            dvd_next = step_dvd;
            rem_next = step_rem;
            cnt_next = cnt_reg + r2a_pkg::DIV_CNT_W'(1);
            if (cnt_reg == r2a_pkg::DIV_CNT_W'(r2a_pkg::DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = r2a_pkg::DIV_W'(req.dividend);
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg[r2a_pkg::VALUE_BITS-1:0];
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/radix_to_ascii_converter.sv =====
// Top level: converts an integer to base-N ASCII text through a digit stack.
//
//  channel  | direction | tdata fields (lsb up)            | tlast
//  s_       | in        | value[30:0], base[35:31]         | -
//  m_       | out       | character[6:0]                   | last (on the NUL)
//
// Each digit goes through the shared radix divider, which retires 8 quotient bits
// per cycle; each output character then passes through the output register.
// The input is ready only while no item is in work. Reset is synchronous and
// clears control state only; the digit stack is not cleared. A stall on m_tready
// holds the sequencer in its emitting state with no character lost.
`default_nettype none

module radix_to_ascii_converter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [r2a_pkg::IN_TDATA_W-1:0]   s_tdata,   // value, base
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [r2a_pkg::OUT_TDATA_W-1:0]       m_tdata,   // character
    output logic                                  m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREFIX,
        ST_PREFIX_X,
        ST_POP,
        ST_NUL
    } state_t;

    state_t                             state_reg, state_next;
    logic [r2a_pkg::VALUE_BITS-1:0]     quot_reg, quot_next;
    logic [r2a_pkg::BASE_W-1:0]         base_reg, base_next;
    logic [r2a_pkg::SP_W-1:0]           sp_reg, sp_next;
    logic                               start_reg, start_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic                               m_tlast_reg, m_tlast_next;
    logic [r2a_pkg::CHAR_W-1:0]         char_reg, char_next;

    logic [r2a_pkg::DIGIT_W-1:0]        digit_stack_reg [r2a_pkg::DIGIT_STACK_DEPTH];
    logic                               push_en;
    logic [r2a_pkg::SP_W-1:0]           sp_dec;

    logic [r2a_pkg::VALUE_BITS-1:0]     in_value;
    logic [r2a_pkg::BASE_W-1:0]         in_base;
    logic                               out_free;

    r2a_pkg::div_req_t                  div_req;
    r2a_pkg::div_rsp_t                  div_rsp;

    assign in_value = s_tdata[r2a_pkg::VALUE_BITS-1:0];
    assign in_base  = s_tdata[r2a_pkg::VALUE_BITS +: r2a_pkg::BASE_W];

    assign div_req.start    = start_reg;
    assign div_req.dividend = quot_reg;
    assign div_req.divisor  = base_reg;

    r2a_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign sp_dec   = sp_reg - r2a_pkg::SP_W'(1);

    always_comb begin
        state_next    = state_reg;
        quot_next     = quot_reg;
        base_next     = base_reg;
        sp_next       = sp_reg;
        start_next    = 1'b0;
        push_en       = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        char_next     = char_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    quot_next = in_value;
                    base_next = in_base;
                    sp_next   = '0;
                    if (in_base < r2a_pkg::BASE_MIN || in_base > r2a_pkg::BASE_MAX) begin
                        quot_next  = '0;
                        state_next = ST_NUL;
                    end else if (in_value == '0) begin
                        state_next = ST_PREFIX;
                    end else begin
                        start_next = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    // A push onto a full stack is dropped, as are its digits.
                    if (sp_reg < r2a_pkg::SP_W'(r2a_pkg::DIGIT_STACK_DEPTH)) begin
                        push_en = 1'b1;
                        sp_next = sp_reg + r2a_pkg::SP_W'(1);
                    end
                    quot_next = div_rsp.quotient;
                    if (div_rsp.quotient == '0) begin
                        state_next = ST_PREFIX;
                    end else begin
                        start_next = 1'b1;
                    end
                end
            end
            ST_PREFIX: begin
                if (base_reg == r2a_pkg::BASE_OCT || base_reg == r2a_pkg::BASE_HEX) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tlast_next  = 1'b0;
                        char_next     = r2a_pkg::CHAR_ZERO;
                        state_next    = (base_reg == r2a_pkg::BASE_HEX) ? ST_PREFIX_X : ST_POP;
                    end
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_PREFIX_X: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b0;
                    char_next     = r2a_pkg::CHAR_X;
                    state_next    = ST_POP;
                end
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    state_next = ST_NUL;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b0;
                    char_next     = r2a_pkg::digit_to_ascii(
                                        digit_stack_reg[sp_dec[r2a_pkg::IDX_W-1:0]]);
                    sp_next       = sp_dec;
                end
            end
            ST_NUL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    char_next     = r2a_pkg::CHAR_NUL;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            quot_reg     <= '0;
            sp_reg       <= '0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            quot_reg     <= quot_next;
            sp_reg       <= sp_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
        base_reg <= base_next;
        char_reg <= char_next;
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            digit_stack_reg[sp_reg[r2a_pkg::IDX_W-1:0]] <= div_rsp.remainder;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {(r2a_pkg::OUT_TDATA_W - r2a_pkg::CHAR_W)'(0), char_reg};

    // The divider reports a result only while the sequencer waits for one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider result outside of the division phase");

    // Every run drains the digit stack before new input is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> sp_reg == '0)
        else $error("digit stack not empty while ready for input");

    // Only the terminating transaction carries a NUL character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[r2a_pkg::CHAR_W-1:0] != r2a_pkg::CHAR_NUL)
        else $error("NUL character without last flag");

    // A new division starts only right after accepting input or a digit push.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> $past(state_reg) == ST_IDLE || $past(div_rsp.done))
        else $error("division started without cause");

endmodule

`default_nettype wire
